[sv/assert_macros.svh]
// Assertion macros shared by the RTL modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define JSU_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition must never be true outside reset
`define JSU_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

[sv/jsu_pkg.sv]
// Types, codes and UTF-8 helpers for the JSON string unescaper
`timescale 1ns / 1ps
`default_nettype none
package jsu_pkg;

    typedef enum logic [2:0] {
        M_IDLE,
        M_BODY,
        M_ESC,
        M_HEX,
        M_HIGH,
        M_HIGH_BS,
        M_LOW_HEX
    } t_mode;

    localparam logic [2:0] ST_BYTE       = 3'd0;
    localparam logic [2:0] ST_END        = 3'd1;
    localparam logic [2:0] ST_NO_QUOTE   = 3'd2;
    localparam logic [2:0] ST_UNTERM_STR = 3'd3;
    localparam logic [2:0] ST_UNTERM_ESC = 3'd4;
    localparam logic [2:0] ST_TRUNC_HEX  = 3'd5;
    localparam logic [2:0] ST_BAD_HEX    = 3'd6;
    localparam logic [2:0] ST_BAD_ESC    = 3'd7;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;

    localparam int          MAX_RES  = 6;
    localparam logic [2:0]  FLUSH_N  = 3'd3;
    localparam logic [5:0]  SURR_TAG = 6'b110110;

    // Up to four result items from one decoding step
    typedef struct packed {
        logic [2:0]      cnt;
        logic [3:0][7:0] data;
        logic [3:0][2:0] stat;
    } t_seg;

    // All result items of one transaction
    typedef struct packed {
        logic [2:0]              cnt;
        logic [MAX_RES-1:0][7:0] data;
        logic [MAX_RES-1:0][2:0] stat;
    } t_bundle;

    function automatic t_seg stat_seg(input logic [2:0] st);
        t_seg s;
        s         = '0;
        s.cnt     = 3'd1;
        s.stat[0] = st;
        return s;
    endfunction

    function automatic t_seg byte_seg(input logic [7:0] b);
        t_seg s;
        s         = '0;
        s.cnt     = 3'd1;
        s.data[0] = b;
        s.stat[0] = ST_BYTE;
        return s;
    endfunction

    function automatic t_seg utf8_seg(input logic [20:0] cp);
        t_seg s;
        s = '0;
        if (cp < 21'h80) begin
            s.cnt     = 3'd1;
            s.data[0] = {1'b0, cp[6:0]};
        end else if (cp < 21'h800) begin
            s.cnt     = 3'd2;
            s.data[0] = {3'b110, cp[10:6]};
            s.data[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            s.cnt     = 3'd3;
            s.data[0] = {4'b1110, cp[15:12]};
            s.data[1] = {2'b10, cp[11:6]};
            s.data[2] = {2'b10, cp[5:0]};
        end else begin
            s.cnt     = 3'd4;
            s.data[0] = {5'b11110, cp[20:18]};
            s.data[1] = {2'b10, cp[17:12]};
            s.data[2] = {2'b10, cp[11:6]};
            s.data[3] = {2'b10, cp[5:0]};
        end
        return s;
    endfunction

    // Returns {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] t;
        logic       ok;
        t  = 8'h00;
        ok = 1'b0;
        if (c inside {[8'h30:8'h39]}) begin
            t  = c - 8'h30;
            ok = 1'b1;
        end else if (c inside {[8'h61:8'h66]}) begin
            t  = c - 8'h57;
            ok = 1'b1;
        end else if (c inside {[8'h41:8'h46]}) begin
            t  = c - 8'h37;
            ok = 1'b1;
        end
        return {ok, t[3:0]};
    endfunction

endpackage
`default_nettype wire

[sv/json_string_unescape_utf8.sv]
// Top level of the JSON string unescaper with UTF-8 output
// A byte held in the input register is decoded combinationally and loaded into the result buffer
// once that buffer is free; its first result is offered from then on.
// Throughput: one byte per cycle while each byte yields at most one result and the output is not
// stalled; a byte with n results holds the result buffer until all n have gone out (up to six for a broken pair).
// Reset: synchronous, active low; scanner returns to waiting for an opening quote
// and both register stages empty.
`timescale 1ns / 1ps
`default_nettype none
module json_string_unescape_utf8 (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_req_type,
    input  wire logic [7:0] i_in_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic [2:0]      o_status,
    output logic            o_last
);

    logic             w_take;
    logic             w_load;
    logic             w_em_free;
    logic             w_valid;
    logic             w_req_type;
    logic [7:0]       w_byte;
    jsu_pkg::t_bundle w_bundle;

    jsu_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_in_byte  (i_in_byte),
        .i_take     (w_take),
        .o_in_ready (o_in_ready),
        .o_valid    (w_valid),
        .o_req_type (w_req_type),
        .o_byte     (w_byte)
    );

    jsu_decode u_dec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid),
        .i_req_type (w_req_type),
        .i_byte     (w_byte),
        .i_em_free  (w_em_free),
        .o_take     (w_take),
        .o_load     (w_load),
        .o_bundle   (w_bundle)
    );

    jsu_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_bundle    (w_bundle),
        .i_out_ready (i_out_ready),
        .o_em_free   (w_em_free),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire

[sv/jsu_in_stage.sv]
// Input register stage: holds one accepted transaction until the decoder takes it
`timescale 1ns / 1ps
`default_nettype none
module jsu_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_req_type,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_take,
    output logic            o_in_ready,
    output logic            o_valid,
    output logic            o_req_type,
    output logic [7:0]      o_byte
);

    logic       r_valid;
    logic       n_valid;
    logic       r_req_type;
    logic [7:0] r_byte;
    logic       w_acc;

    assign o_in_ready = !r_valid || i_take;
    assign w_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_acc) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_req_type <= i_req_type;
            r_byte     <= i_in_byte;
        end
    end

    assign o_valid    = r_valid;
    assign o_req_type = r_req_type;
    assign o_byte     = r_byte;

endmodule
`default_nettype wire

[sv/jsu_decode.sv]
// Scanner state and decoding of one byte into its list of result items
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module jsu_decode (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic       i_req_type,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_em_free,
    output logic            o_take,
    output logic            o_load,
    output jsu_pkg::t_bundle o_bundle
);

    jsu_pkg::t_mode r_mode;
    jsu_pkg::t_mode n_mode;
    logic [15:0]    r_hex;
    logic [15:0]    n_hex;
    logic [1:0]     r_dcnt;
    logic [1:0]     n_dcnt;
    logic [9:0]     r_ph;
    logic [9:0]     n_ph;

    logic           w_eoi;
    logic [7:0]     w_c;
    logic           w_flush;
    jsu_pkg::t_seg  w_seg;
    jsu_pkg::t_seg  w_flush_seg;

    jsu_pkg::t_seg  w_body_seg;
    jsu_pkg::t_mode w_body_mode;
    jsu_pkg::t_seg  w_esc_seg;
    jsu_pkg::t_mode w_esc_mode;

    logic [4:0]     w_hx;
    logic [15:0]    w_new_hex;
    logic           w_is_low;
    logic           w_is_high;
    logic [20:0]    w_pair_cp;
    logic           w_low_phase;

    assign w_eoi = i_req_type;
    assign w_c   = i_byte;

    // body byte
    always_comb begin
        w_body_seg  = '0;
        w_body_mode = jsu_pkg::M_BODY;
        if (w_c == jsu_pkg::CH_QUOTE) begin
            w_body_seg  = jsu_pkg::stat_seg(jsu_pkg::ST_END);
            w_body_mode = jsu_pkg::M_IDLE;
        end else if (w_c == jsu_pkg::CH_BSLASH) begin
            w_body_mode = jsu_pkg::M_ESC;
        end else begin
            w_body_seg = jsu_pkg::byte_seg(w_c);
        end
    end

    // escape letter; the 'u' case is handled by the caller
    always_comb begin
        w_esc_seg  = '0;
        w_esc_mode = jsu_pkg::M_BODY;
        case (w_c)
            jsu_pkg::CH_QUOTE:  w_esc_seg = jsu_pkg::byte_seg(jsu_pkg::CH_QUOTE);
            jsu_pkg::CH_BSLASH: w_esc_seg = jsu_pkg::byte_seg(jsu_pkg::CH_BSLASH);
            jsu_pkg::CH_SLASH:  w_esc_seg = jsu_pkg::byte_seg(jsu_pkg::CH_SLASH);
            jsu_pkg::CH_LC_B:   w_esc_seg = jsu_pkg::byte_seg(jsu_pkg::CH_BS);
            jsu_pkg::CH_LC_F:   w_esc_seg = jsu_pkg::byte_seg(jsu_pkg::CH_FF);
            jsu_pkg::CH_LC_N:   w_esc_seg = jsu_pkg::byte_seg(jsu_pkg::CH_LF);
            jsu_pkg::CH_LC_R:   w_esc_seg = jsu_pkg::byte_seg(jsu_pkg::CH_CR);
            jsu_pkg::CH_LC_T:   w_esc_seg = jsu_pkg::byte_seg(jsu_pkg::CH_TAB);
            jsu_pkg::CH_LC_U:   w_esc_mode = jsu_pkg::M_HEX;
            default: begin
                w_esc_seg  = jsu_pkg::stat_seg(jsu_pkg::ST_BAD_ESC);
                w_esc_mode = jsu_pkg::M_IDLE;
            end
        endcase
    end

    // hex digit step
    assign w_hx        = jsu_pkg::hex_digit(w_c);
    assign w_new_hex   = {r_hex[11:0], w_hx[3:0]};
    assign w_is_low    = (w_new_hex >= 16'hDC00) && (w_new_hex <= 16'hDFFF);
    assign w_is_high   = (w_new_hex >= 16'hD800) && (w_new_hex <= 16'hDBFF);
    assign w_pair_cp   = 21'h10000 + {1'b0, r_ph, w_new_hex[9:0]};
    assign w_low_phase = (r_mode == jsu_pkg::M_LOW_HEX);
    assign w_flush_seg = jsu_pkg::utf8_seg({5'd0, jsu_pkg::SURR_TAG, r_ph});

    always_comb begin
        n_mode  = r_mode;
        n_hex   = r_hex;
        n_dcnt  = r_dcnt;
        n_ph    = r_ph;
        w_flush = 1'b0;
        w_seg   = '0;
        case (r_mode)
            jsu_pkg::M_IDLE: begin
                if (!w_eoi && w_c == jsu_pkg::CH_QUOTE) begin
                    n_mode = jsu_pkg::M_BODY;
                end else begin
                    w_seg = jsu_pkg::stat_seg(jsu_pkg::ST_NO_QUOTE);
                end
            end
            jsu_pkg::M_BODY: begin
                if (w_eoi) begin
                    w_seg  = jsu_pkg::stat_seg(jsu_pkg::ST_UNTERM_STR);
                    n_mode = jsu_pkg::M_IDLE;
                end else begin
                    w_seg  = w_body_seg;
                    n_mode = w_body_mode;
                end
            end
            jsu_pkg::M_ESC: begin
                if (w_eoi) begin
                    w_seg  = jsu_pkg::stat_seg(jsu_pkg::ST_UNTERM_ESC);
                    n_mode = jsu_pkg::M_IDLE;
                end else begin
                    w_seg  = w_esc_seg;
                    n_mode = w_esc_mode;
                    if (w_c == jsu_pkg::CH_LC_U) begin
                        n_hex  = '0;
                        n_dcnt = '0;
                    end
                end
            end
            jsu_pkg::M_HIGH: begin
                if (!w_eoi && w_c == jsu_pkg::CH_BSLASH) begin
                    n_mode = jsu_pkg::M_HIGH_BS;
                end else begin
                    w_flush = 1'b1;
                    if (w_eoi) begin
                        w_seg  = jsu_pkg::stat_seg(jsu_pkg::ST_UNTERM_STR);
                        n_mode = jsu_pkg::M_IDLE;
                    end else begin
                        w_seg  = w_body_seg;
                        n_mode = w_body_mode;
                    end
                end
            end
            jsu_pkg::M_HIGH_BS: begin
                if (!w_eoi && w_c == jsu_pkg::CH_LC_U) begin
                    n_hex  = '0;
                    n_dcnt = '0;
                    n_mode = jsu_pkg::M_LOW_HEX;
                end else begin
                    w_flush = 1'b1;
                    if (w_eoi) begin
                        w_seg  = jsu_pkg::stat_seg(jsu_pkg::ST_UNTERM_ESC);
                        n_mode = jsu_pkg::M_IDLE;
                    end else begin
                        w_seg  = w_esc_seg;
                        n_mode = w_esc_mode;
                    end
                end
            end
            jsu_pkg::M_HEX, jsu_pkg::M_LOW_HEX: begin
                if (w_eoi) begin
                    w_seg  = jsu_pkg::stat_seg(jsu_pkg::ST_TRUNC_HEX);
                    n_mode = jsu_pkg::M_IDLE;
                end else if (!w_hx[4]) begin
                    w_seg  = jsu_pkg::stat_seg(jsu_pkg::ST_BAD_HEX);
                    n_mode = jsu_pkg::M_IDLE;
                end else begin
                    n_hex = w_new_hex;
                    if (r_dcnt != 2'd3) begin
                        n_dcnt = r_dcnt + 2'd1;
                    end else begin
                        n_dcnt = '0;
                        if (w_low_phase && w_is_low) begin
                            w_seg  = jsu_pkg::utf8_seg(w_pair_cp);
                            n_mode = jsu_pkg::M_BODY;
                        end else begin
                            // unpaired high goes out first as three bytes
                            w_flush = w_low_phase;
                            if (w_is_high) begin
                                n_ph   = w_new_hex[9:0];
                                n_mode = jsu_pkg::M_HIGH;
                            end else begin
                                w_seg  = jsu_pkg::utf8_seg({5'd0, w_new_hex});
                                n_mode = jsu_pkg::M_BODY;
                            end
                        end
                    end
                end
            end
            default: n_mode = jsu_pkg::M_IDLE;
        endcase
    end

    // join the flushed surrogate and the step's own items
    always_comb begin
        o_bundle = '0;
        if (w_flush) begin
            o_bundle.cnt = jsu_pkg::FLUSH_N + w_seg.cnt;
            for (int k = 0; k < 3; k++) begin
                o_bundle.data[k]   = w_flush_seg.data[k];
                o_bundle.stat[k]   = w_flush_seg.stat[k];
                o_bundle.data[k+3] = w_seg.data[k];
                o_bundle.stat[k+3] = w_seg.stat[k];
            end
        end else begin
            o_bundle.cnt = w_seg.cnt;
            for (int k = 0; k < 4; k++) begin
                o_bundle.data[k] = w_seg.data[k];
                o_bundle.stat[k] = w_seg.stat[k];
            end
        end
    end

    assign o_take = i_valid && (o_bundle.cnt == 3'd0 || i_em_free);
    assign o_load = o_take && (o_bundle.cnt != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= jsu_pkg::M_IDLE;
            r_hex  <= '0;
            r_dcnt <= '0;
            r_ph   <= '0;
        end else if (o_take) begin
            r_mode <= n_mode;
            r_hex  <= n_hex;
            r_dcnt <= n_dcnt;
            r_ph   <= n_ph;
        end
    end

    `JSU_NEVER(a_bundle_max, i_clk, i_rst_n, o_bundle.cnt > 3'd6)
    `JSU_ASSERT(a_quote_opens, i_clk, i_rst_n, (o_take && r_mode == jsu_pkg::M_IDLE && o_bundle.cnt == 3'd0) |=> (r_mode == jsu_pkg::M_BODY))

endmodule
`default_nettype wire

[sv/jsu_emit.sv]
// Result buffer: holds one transaction's items and hands them out one per cycle while the output is ready
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module jsu_emit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire jsu_pkg::t_bundle i_bundle,
    input  wire logic             i_out_ready,
    output logic                  o_em_free,
    output logic                  o_out_valid,
    output logic [7:0]            o_out_byte,
    output logic [2:0]            o_status,
    output logic                  o_last
);

    logic [2:0]                       r_cnt;
    logic [2:0]                       n_cnt;
    logic [jsu_pkg::MAX_RES-1:0][7:0] r_data;
    logic [jsu_pkg::MAX_RES-1:0][7:0] n_data;
    logic [jsu_pkg::MAX_RES-1:0][2:0] r_stat;
    logic [jsu_pkg::MAX_RES-1:0][2:0] n_stat;
    logic                             w_pop;

    assign o_out_valid = (r_cnt != 3'd0);
    assign w_pop       = o_out_valid && i_out_ready;
    assign o_em_free   = (r_cnt == 3'd0) || (r_cnt == 3'd1 && i_out_ready);

    always_comb begin
        n_cnt  = r_cnt;
        n_data = r_data;
        n_stat = r_stat;
        if (i_load) begin
            n_cnt  = i_bundle.cnt;
            n_data = i_bundle.data;
            n_stat = i_bundle.stat;
        end else if (w_pop) begin
            // advance the queue by one item
            n_cnt = r_cnt - 3'd1;
            for (int k = 0; k < jsu_pkg::MAX_RES - 1; k++) begin
                n_data[k] = r_data[k+1];
                n_stat[k] = r_stat[k+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_stat <= n_stat;
    end

    assign o_out_byte = r_data[0];
    assign o_status   = r_stat[0];
    assign o_last     = (r_cnt == 3'd1);

    `JSU_NEVER(a_cnt_max, i_clk, i_rst_n, r_cnt > 3'd6)
    `JSU_NEVER(a_load_busy, i_clk, i_rst_n, i_load && !o_em_free)
    `JSU_ASSERT(a_pop_step, i_clk, i_rst_n, (w_pop && !i_load && r_cnt > 3'd1) |=> ((r_cnt + 3'd1) == $past(r_cnt)))

endmodule
`default_nettype wire

[verif/json_string_unescape_utf8_tb.sv]
// Self-checking testbench for the JSON string unescaper with UTF-8 output
`timescale 1ns / 1ps
module json_string_unescape_utf8_tb;
    import jsu_pkg::*;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       i_req_type  = 1'b0;
    logic [7:0] i_in_byte   = 8'h00;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic [2:0] o_status;
    logic       o_last;

    json_string_unescape_utf8 DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_in_byte   (i_in_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // One decoded result item
    typedef struct packed {
        logic [7:0] b;
        logic [2:0] st;
        logic       last;
    } t_res;

    // Directed row: input item plus an optional typed single result
    typedef struct packed {
        logic       eoi;
        logic [7:0] b;
        logic       chk;
        logic [7:0] eb;
        logic [2:0] es;
    } t_row;

    localparam int N_DIR  = 34;
    localparam int N_RAND = 276;

    t_row dir_tab [N_DIR] = '{
        '{1'b0, "a",       1'b1, 8'h00,    ST_NO_QUOTE},
        '{1'b1, CH_QUOTE,  1'b1, 8'h00,    ST_NO_QUOTE},
        '{1'b0, CH_QUOTE,  1'b0, 8'h00,    ST_BYTE},
        '{1'b0, 8'h00,     1'b1, 8'h00,    ST_BYTE},
        '{1'b0, 8'hFF,     1'b1, 8'hFF,    ST_BYTE},
        '{1'b0, CH_BSLASH, 1'b0, 8'h00,    ST_BYTE},
        '{1'b0, CH_QUOTE,  1'b1, CH_QUOTE, ST_BYTE},
        '{1'b0, CH_BSLASH, 1'b0, 8'h00,    ST_BYTE},
        '{1'b0, CH_LC_T,   1'b1, CH_TAB,   ST_BYTE},
        '{1'b0, CH_BSLASH, 1'b0, 8'h00,    ST_BYTE},
        '{1'b0, CH_LC_U,   1'b0, 8'h00,    ST_BYTE},
        '{1'b0, "D",       1'b0, 8'h00,    ST_BYTE},
        '{1'b0, "8",       1'b0, 8'h00,    ST_BYTE},
        '{1'b0, "0",       1'b0, 8'h00,    ST_BYTE},
        '{1'b0, "0",       1'b0, 8'h00,    ST_BYTE},
        '{1'b0, "x",       1'b0, 8'h00,    ST_BYTE},
        '{1'b0, CH_BSLASH, 1'b0, 8'h00,    ST_BYTE},
        '{1'b0, "q",       1'b1, 8'h00,    ST_BAD_ESC},
        '{1'b0, CH_QUOTE,  1'b0, 8'h00,    ST_BYTE},
        '{1'b0, CH_BSLASH, 1'b0, 8'h00,    ST_BYTE},
        '{1'b0, CH_LC_U,   1'b0, 8'h00,    ST_BYTE},
        '{1'b0, "A",       1'b0, 8'h00,    ST_BYTE},
        '{1'b0, "g",       1'b1, 8'h00,    ST_BAD_HEX},
        '{1'b0, CH_QUOTE,  1'b0, 8'h00,    ST_BYTE},
        '{1'b0, CH_BSLASH, 1'b0, 8'h00,    ST_BYTE},
        '{1'b0, CH_LC_U,   1'b0, 8'h00,    ST_BYTE},
        '{1'b1, 8'hFF,     1'b1, 8'h00,    ST_TRUNC_HEX},
        '{1'b0, CH_QUOTE,  1'b0, 8'h00,    ST_BYTE},
        '{1'b0, CH_BSLASH, 1'b0, 8'h00,    ST_BYTE},
        '{1'b1, 8'hAA,     1'b1, 8'h00,    ST_UNTERM_ESC},
        '{1'b0, CH_QUOTE,  1'b0, 8'h00,    ST_BYTE},
        '{1'b1, 8'h55,     1'b1, 8'h00,    ST_UNTERM_STR},
        '{1'b0, CH_QUOTE,  1'b0, 8'h00,    ST_BYTE},
        '{1'b0, CH_QUOTE,  1'b1, 8'h00,    ST_END}
    };

    // Typed expectation that travels with the current transaction
    logic       row_chk = 1'b0;
    logic [7:0] row_eb  = 8'h00;
    logic [2:0] row_es  = ST_BYTE;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int err_cnt      = 0;
    int n_sent       = 0;
    int n_acc        = 0;
    int n_res        = 0;
    logic [7:0] st_seen = 8'h00;

    t_res dec_q[$];

    // Decoder state mirror
    t_mode       dec_mode = M_IDLE;
    logic [15:0] dec_acc  = 16'h0000;
    logic [1:0]  dec_ndig = 2'd0;
    logic [9:0]  dec_hi   = 10'h000;
    t_res        step_res [MAX_RES];
    int          step_n;

    // Append one expected result at the tail of the queue
    function automatic void exp_put(input t_res r);
        dec_q.insert(dec_q.size(), r);
    endfunction

    function automatic void emit_res(input logic [7:0] b, input logic [2:0] st);
        if (step_n < MAX_RES) begin
            step_res[step_n] = '{b, st, 1'b0};
            step_n++;
        end
    endfunction

    function automatic void emit_cp(input logic [20:0] cp);
        if (cp < 21'h80) begin
            emit_res(cp[7:0], ST_BYTE);
        end else if (cp < 21'h800) begin
            emit_res({3'b110, cp[10:6]}, ST_BYTE);
            emit_res({2'b10, cp[5:0]}, ST_BYTE);
        end else if (cp < 21'h10000) begin
            emit_res({4'b1110, cp[15:12]}, ST_BYTE);
            emit_res({2'b10, cp[11:6]}, ST_BYTE);
            emit_res({2'b10, cp[5:0]}, ST_BYTE);
        end else begin
            emit_res({5'b11110, cp[20:18]}, ST_BYTE);
            emit_res({2'b10, cp[17:12]}, ST_BYTE);
            emit_res({2'b10, cp[11:6]}, ST_BYTE);
            emit_res({2'b10, cp[5:0]}, ST_BYTE);
        end
    endfunction

    function automatic void emit_err(input logic [2:0] st);
        emit_res(8'h00, st);
        dec_mode = M_IDLE;
    endfunction

    function automatic void dec_body(input logic [7:0] c);
        if (c == CH_QUOTE) begin
            emit_res(8'h00, ST_END);
            dec_mode = M_IDLE;
        end else if (c == CH_BSLASH) begin
            dec_mode = M_ESC;
        end else begin
            emit_res(c, ST_BYTE);
            dec_mode = M_BODY;
        end
    endfunction

    function automatic void dec_escape(input logic [7:0] c);
        dec_mode = M_BODY;
        case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: emit_res(c, ST_BYTE);
            CH_LC_B: emit_res(CH_BS, ST_BYTE);
            CH_LC_F: emit_res(CH_FF, ST_BYTE);
            CH_LC_N: emit_res(CH_LF, ST_BYTE);
            CH_LC_R: emit_res(CH_CR, ST_BYTE);
            CH_LC_T: emit_res(CH_TAB, ST_BYTE);
            CH_LC_U: begin
                dec_acc  = 16'h0000;
                dec_ndig = 2'd0;
                dec_mode = M_HEX;
            end
            default: emit_err(ST_BAD_ESC);
        endcase
    endfunction

    // A high surrogate waits for its pair, anything else goes out now
    function automatic void dec_codepoint(input logic [15:0] cp);
        if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
            dec_hi   = cp[9:0];
            dec_mode = M_HIGH;
        end else begin
            emit_cp({5'd0, cp});
            dec_mode = M_BODY;
        end
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic void dec_hexdigit(input logic [7:0] c, input logic low);
        int          d;
        logic [15:0] cp;
        d = hex_nibble(c);
        if (d < 0) begin
            emit_err(ST_BAD_HEX);
            return;
        end
        dec_acc = {dec_acc[11:0], d[3:0]};
        if (dec_ndig != 2'd3) begin
            dec_ndig = dec_ndig + 2'd1;
            return;
        end
        dec_ndig = 2'd0;
        cp       = dec_acc;
        if (!low) begin
            dec_codepoint(cp);
        end else if (cp >= 16'hDC00 && cp <= 16'hDFFF) begin
            emit_cp(21'h10000 + {1'b0, dec_hi, 10'h000} + {11'd0, cp[9:0]});
            dec_mode = M_BODY;
        end else begin
            emit_cp(21'hD800 + {11'd0, dec_hi});
            dec_codepoint(cp);
        end
    endfunction

    // Advance the mirror by one input item and collect what it produces
    function automatic void decode_item(input logic eoi, input logic [7:0] c);
        step_n = 0;
        case (dec_mode)
            M_BODY: if (eoi) emit_err(ST_UNTERM_STR); else dec_body(c);
            M_ESC: if (eoi) emit_err(ST_UNTERM_ESC); else dec_escape(c);
            M_HEX: if (eoi) emit_err(ST_TRUNC_HEX); else dec_hexdigit(c, 1'b0);
            M_HIGH: begin
                if (!eoi && c == CH_BSLASH) begin
                    dec_mode = M_HIGH_BS;
                end else begin
                    emit_cp(21'hD800 + {11'd0, dec_hi});
                    if (eoi) emit_err(ST_UNTERM_STR); else dec_body(c);
                end
            end
            M_HIGH_BS: begin
                if (!eoi && c == CH_LC_U) begin
                    dec_acc  = 16'h0000;
                    dec_ndig = 2'd0;
                    dec_mode = M_LOW_HEX;
                end else begin
                    emit_cp(21'hD800 + {11'd0, dec_hi});
                    if (eoi) emit_err(ST_UNTERM_ESC); else dec_escape(c);
                end
            end
            M_LOW_HEX: if (eoi) emit_err(ST_TRUNC_HEX); else dec_hexdigit(c, 1'b1);
            default: begin
                if (!eoi && c == CH_QUOTE) dec_mode = M_BODY;
                else emit_err(ST_NO_QUOTE);
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (rx_stall_pct == 0) i_out_ready <= 1'b1;
        else i_out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Predict on each input transaction, check on each output transaction
    always @(posedge i_clk) begin
        t_res exp_r;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                n_acc++;
                decode_item(i_req_type, i_in_byte);
                if (row_chk) begin
                    // typed row: its single result stands in for the mirror's
                    exp_put(t_res'{row_eb, row_es, 1'b1});
                end else begin
                    for (int i = 0; i < step_n; i++) begin
                        exp_put(t_res'{step_res[i].b, step_res[i].st, (i == step_n - 1)});
                    end
                end
            end
            if (o_out_valid && i_out_ready) begin
                n_res++;
                st_seen[o_status] = 1'b1;
                if (dec_q.size() == 0) begin
                    $error("unexpected result: out_byte %02h status %0d last %0d",
                           o_out_byte, o_status, o_last);
                    err_cnt++;
                end else begin
                    exp_r = dec_q.pop_front();
                    if (o_out_byte !== exp_r.b) begin
                        $error("out_byte: expected %02h, got %02h", exp_r.b, o_out_byte);
                        err_cnt++;
                    end
                    if (o_status !== exp_r.st) begin
                        $error("status: expected %0d, got %0d", exp_r.st, o_status);
                        err_cnt++;
                    end
                    if (o_last !== exp_r.last) begin
                        $error("last: expected %0d, got %0d", exp_r.last, o_last);
                        err_cnt++;
                    end
                end
            end
        end
    end

    task automatic push_item(input logic eoi, input logic [7:0] b, input logic chk,
                             input logic [7:0] eb, input logic [2:0] es);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_req_type <= eoi;
        i_in_byte  <= b;
        row_chk    <= chk;
        row_eb     <= eb;
        row_es     <= es;
        do @(posedge i_clk); while (!o_in_ready);
        n_sent++;
    endtask

    task automatic send_byte(input logic [7:0] c);
        push_item(1'b0, c, 1'b0, 8'h00, ST_BYTE);
    endtask

    task automatic send_eoi();
        push_item(1'b1, 8'($urandom_range(0, 255)), 1'b0, 8'h00, ST_BYTE);
    endtask

    // Hold the sender until every expected result has drained
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (dec_q.size() != 0);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'("0") + {4'd0, n};
        if ($urandom_range(0, 1) == 0) return 8'("a") + {4'd0, n} - 8'd10;
        return 8'("A") + {4'd0, n} - 8'd10;
    endfunction

    task automatic send_digits(input logic [15:0] v, input int n);
        for (int i = 3; i > 3 - n; i--) send_byte(hex_char(v[i*4 +: 4]));
    endtask

    task automatic send_uesc(input logic [15:0] v);
        send_byte(CH_BSLASH);
        send_byte(CH_LC_U);
        send_digits(v, 4);
    endtask

    function automatic logic [7:0] pick_esc();
        case ($urandom_range(0, 7))
            0: return CH_QUOTE;
            1: return CH_BSLASH;
            2: return CH_SLASH;
            3: return CH_LC_B;
            4: return CH_LC_F;
            5: return CH_LC_N;
            6: return CH_LC_R;
            default: return CH_LC_T;
        endcase
    endfunction

    function automatic logic [7:0] pick_bad_esc();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LC_B, CH_LC_F, CH_LC_N,
                         CH_LC_R, CH_LC_T, CH_LC_U});
        return b;
    endfunction

    function automatic logic [15:0] pick_non_low();
        logic [15:0] v;
        do v = 16'($urandom_range(0, 16'hFFFF)); while (v >= 16'hDC00 && v <= 16'hDFFF);
        return v;
    endfunction

    // One string literal: mostly well formed, sometimes preceded by noise or broken
    task automatic gen_string();
        logic [7:0] b;
        int         n;
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_eoi();
                end else begin
                    do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
                    send_byte(b);
                end
            end
        end
        send_byte(CH_QUOTE);
        n = $urandom_range(0, 6);
        repeat (n) begin
            case ($urandom_range(0, 11))
                0, 1, 2: begin
                    do b = 8'($urandom_range(0, 255));
                    while (b == CH_QUOTE || b == CH_BSLASH);
                    send_byte(b);
                end
                3: begin
                    send_byte(CH_BSLASH);
                    send_byte(pick_esc());
                end
                4: send_uesc(16'($urandom_range(0, 16'hFFFF)));
                5: send_uesc(16'($urandom_range(0, 16'h07FF)));
                6: begin
                    send_uesc(16'($urandom_range(16'hD800, 16'hDBFF)));
                    send_uesc(16'($urandom_range(16'hDC00, 16'hDFFF)));
                end
                7: send_uesc(16'($urandom_range(16'hDC00, 16'hDFFF)));
                8: send_uesc(16'($urandom_range(16'hD800, 16'hDBFF)));
                9: begin
                    send_uesc(16'($urandom_range(16'hD800, 16'hDBFF)));
                    send_uesc(pick_non_low());
                end
                10: begin
                    send_uesc(16'($urandom_range(16'hD800, 16'hDBFF)));
                    send_byte(CH_BSLASH);
                    send_byte(($urandom_range(0, 1) == 0) ? pick_esc() : pick_bad_esc());
                end
                default: send_uesc(16'($urandom_range(16'h0800, 16'hFFFF)));
            endcase
        end
        case ($urandom_range(0, 9))
            6: send_eoi();
            7: begin
                send_byte(CH_BSLASH);
                send_byte(pick_bad_esc());
            end
            8, 9: begin
                send_byte(CH_BSLASH);
                send_byte(CH_LC_U);
                send_digits(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3));
                if ($urandom_range(0, 1) == 0) begin
                    send_eoi();
                end else begin
                    do b = 8'($urandom_range(0, 255)); while (hex_nibble(b) >= 0);
                    send_byte(b);
                end
            end
            default: send_byte(CH_QUOTE);
        endcase
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++) begin
            push_item(dir_tab[i].eoi, dir_tab[i].b, dir_tab[i].chk,
                      dir_tab[i].eb, dir_tab[i].es);
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 61; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 61; end
                default: begin tx_idle_pct = 20; rx_stall_pct = 20; end
            endcase
            while (n_sent < N_DIR + (N_RAND * (ph + 1)) / 4) gen_string();
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (dec_q.size() != 0) begin
            $error("%0d expected results never arrived", dec_q.size());
            err_cnt++;
        end
        $display("covered %0d input transactions and %0d result transactions", n_acc, n_res);
        $display("status codes observed (bit per code): %b", st_seen);
        if (err_cnt == 0) begin
            $display("json_string_unescape_utf8_tb: done, clean");
        end else begin
            $display("json_string_unescape_utf8_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout waiting for the decoder");
        $display("json_string_unescape_utf8_tb: done, errors");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/jsu_pkg.sv
sv/jsu_in_stage.sv
sv/jsu_decode.sv
sv/jsu_emit.sv
sv/json_string_unescape_utf8.sv
verif/json_string_unescape_utf8_tb.sv
